/* rtl/core/bft_pkg.sv */
// shared types and constants for the breadth-first traversal block
package bft_pkg;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned VERTEX_W = 6;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_APPEND   = 2'd0,
    ACT_CLEAR    = 2'd1,
    ACT_TRAVERSE = 2'd2
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_VISIT       = 2'd0,
    ST_APPEND_OK   = 2'd1,
    ST_APPEND_DROP = 2'd2,
    ST_CLEAR_DONE  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPEND,
    S_CLEAR,
    S_POP,
    S_FETCH,
    S_DEG,
    S_SCAN,
    S_CHECK
  } state_e;

endpackage

/* rtl/core/bft_in_if.sv */
// command channel: action, vertex and neighbor with valid/ready
interface bft_in_if;
  logic                          valid;
  logic                          ready;
  logic [bft_pkg::ACTION_W-1:0]  action;
  logic [bft_pkg::VERTEX_W-1:0]  vertex;
  logic [bft_pkg::VERTEX_W-1:0]  neighbor;

  modport source (output valid, output action, output vertex, output neighbor, input ready);
  modport sink   (input valid, input action, input vertex, input neighbor, output ready);
endinterface

/* rtl/core/bft_out_if.sv */
// result channel: status, visited vertex and last flag with valid/ready
interface bft_out_if;
  logic                          valid;
  logic                          ready;
  logic [bft_pkg::STATUS_W-1:0]  status;
  logic [bft_pkg::VERTEX_W-1:0]  visited_vertex;
  logic                          last;

  modport source (output valid, output status, output visited_vertex, output last, input ready);
  modport sink   (input valid, input status, input visited_vertex, input last, output ready);
endinterface

/* rtl/core/bft_adj_mem.sv */
// adjacency storage: neighbor list memory and per-vertex degree memory
module bft_adj_mem #(
  parameter int unsigned VW         = 6,
  parameter int unsigned MAX_DEGREE = 8,
  parameter int unsigned DW         = 4,
  parameter int unsigned NAW        = 9
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            deg_rd_en_i,
  input  logic [VW-1:0]   deg_rd_addr_i,
  output logic [DW-1:0]   deg_rd_data_o,
  input  logic            deg_wr_en_i,
  input  logic [VW-1:0]   deg_wr_addr_i,
  input  logic [DW-1:0]   deg_wr_data_i,
  input  logic            deg_clear_i,
  input  logic            nbr_rd_en_i,
  input  logic [NAW-1:0]  nbr_rd_addr_i,
  output logic [VW-1:0]   nbr_rd_data_o,
  input  logic            nbr_wr_en_i,
  input  logic [NAW-1:0]  nbr_wr_addr_i,
  input  logic [VW-1:0]   nbr_wr_data_i
);

  localparam int unsigned NV_SLOTS  = 2 ** VW;
  localparam int unsigned NBR_DEPTH = NV_SLOTS * MAX_DEGREE;

  logic [DW-1:0]       deg_mem [NV_SLOTS];
  logic [VW-1:0]       nbr_mem [NBR_DEPTH];
  logic [NV_SLOTS-1:0] deg_vld_q;
  logic                deg_rd_vld_q;
  logic [DW-1:0]       deg_rd_q;
  logic [VW-1:0]       nbr_rd_q;

  // an entry without its valid bit reads as an empty list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deg_vld_q    <= '0;
      deg_rd_vld_q <= 1'b0;
    end else begin
      if (deg_clear_i) begin
        deg_vld_q <= '0;
      end else if (deg_wr_en_i) begin
        deg_vld_q[deg_wr_addr_i] <= 1'b1;
      end
      if (deg_rd_en_i) begin
        deg_rd_vld_q <= deg_vld_q[deg_rd_addr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (deg_wr_en_i) begin
      deg_mem[deg_wr_addr_i] <= deg_wr_data_i;
    end
    if (deg_rd_en_i) begin
      deg_rd_q <= deg_mem[deg_rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (nbr_wr_en_i) begin
      nbr_mem[nbr_wr_addr_i] <= nbr_wr_data_i;
    end
    if (nbr_rd_en_i) begin
      nbr_rd_q <= nbr_mem[nbr_rd_addr_i];
    end
  end

  assign deg_rd_data_o = deg_rd_vld_q ? deg_rd_q : '0;
  assign nbr_rd_data_o = nbr_rd_q;

endmodule

/* rtl/core/bft_vfifo.sv */
// vertex queue memory, addressed by the head and tail pointers of the sequencer
module bft_vfifo #(
  parameter int unsigned VW = 6
) (
  input  logic           clk_i,
  input  logic           wr_en_i,
  input  logic [VW-1:0]  wr_addr_i,
  input  logic [VW-1:0]  wr_data_i,
  input  logic           rd_en_i,
  input  logic [VW-1:0]  rd_addr_i,
  output logic [VW-1:0]  rd_data_o
);

  logic [VW-1:0] mem [2 ** VW];
  logic [VW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

/* rtl/core/bft_ctrl.sv */
// sequencer: command decode, visited map, queue pointers and result register
module bft_ctrl #(
  parameter int unsigned NV         = 64,
  parameter int unsigned VW         = 6,
  parameter int unsigned MAX_DEGREE = 8,
  parameter int unsigned DW         = 4,
  parameter int unsigned NAW        = 9
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  bft_in_if.sink          req_i,
  bft_out_if.source       rsp_o,
  output logic            deg_rd_en_o,
  output logic [VW-1:0]   deg_rd_addr_o,
  input  logic [DW-1:0]   deg_rd_data_i,
  output logic            deg_wr_en_o,
  output logic [VW-1:0]   deg_wr_addr_o,
  output logic [DW-1:0]   deg_wr_data_o,
  output logic            deg_clear_o,
  output logic            nbr_rd_en_o,
  output logic [NAW-1:0]  nbr_rd_addr_o,
  input  logic [VW-1:0]   nbr_rd_data_i,
  output logic            nbr_wr_en_o,
  output logic [NAW-1:0]  nbr_wr_addr_o,
  output logic [VW-1:0]   nbr_wr_data_o,
  output logic            q_wr_en_o,
  output logic [VW-1:0]   q_wr_addr_o,
  output logic [VW-1:0]   q_wr_data_o,
  output logic            q_rd_en_o,
  output logic [VW-1:0]   q_rd_addr_o,
  input  logic [VW-1:0]   q_rd_data_i
);

  localparam int unsigned NV_SLOTS = 2 ** VW;
  localparam logic [VW:0]    NV_PTR = (VW+1)'(NV);
  localparam logic [DW-1:0]  MAXD   = DW'(MAX_DEGREE);
  localparam logic [NAW-1:0] MAXD_A = NAW'(MAX_DEGREE);

  bft_pkg::state_e state_q, state_d;

  logic [bft_pkg::ACTION_W-1:0] act_q, act_d;
  logic [bft_pkg::VERTEX_W-1:0] vtx_q, vtx_d;
  logic [bft_pkg::VERTEX_W-1:0] nbr_q, nbr_d;
  logic [VW:0]                  head_q, head_d;
  logic [VW:0]                  tail_q, tail_d;
  logic [NV_SLOTS-1:0]          visited_q, visited_d;
  logic [VW-1:0]                cur_q, cur_d;
  logic [DW-1:0]                deg_q, deg_d;
  logic [DW-1:0]                idx_q, idx_d;
  logic                         pend_valid_q, pend_valid_d;
  logic [VW-1:0]                pend_vtx_q, pend_vtx_d;

  logic                         out_valid_q;
  logic [bft_pkg::STATUS_W-1:0] out_status_q;
  logic [bft_pkg::VERTEX_W-1:0] out_vtx_q;
  logic                         out_last_q;

  logic                     in_fire;
  logic                     emit_ok;
  logic                     start_ok;
  logic                     append_ok;
  logic                     emit;
  bft_pkg::status_e         emit_status;
  logic [VW-1:0]            emit_vtx;
  logic                     emit_last;

  assign req_i.ready = (state_q == bft_pkg::S_IDLE);
  assign in_fire     = req_i.valid && req_i.ready;
  // the result register frees up in the same cycle as its transfer
  assign emit_ok     = !out_valid_q || rsp_o.ready;
  assign start_ok    = (32'(req_i.vertex) < NV);
  assign append_ok   = (32'(vtx_q) < NV) && (32'(nbr_q) < NV) && (deg_rd_data_i < MAXD);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bft_pkg::S_IDLE: begin
        if (in_fire) begin
          unique case (req_i.action)
            bft_pkg::ACT_APPEND:   state_d = bft_pkg::S_APPEND;
            bft_pkg::ACT_CLEAR:    state_d = bft_pkg::S_CLEAR;
            bft_pkg::ACT_TRAVERSE: state_d = start_ok ? bft_pkg::S_POP : bft_pkg::S_IDLE;
            default:               state_d = bft_pkg::S_IDLE;
          endcase
        end
      end
      bft_pkg::S_APPEND,
      bft_pkg::S_CLEAR: begin
        if (emit_ok) begin
          state_d = bft_pkg::S_IDLE;
        end
      end
      bft_pkg::S_POP: begin
        if (head_q < tail_q) begin
          state_d = bft_pkg::S_FETCH;
        end else if (emit_ok) begin
          state_d = bft_pkg::S_IDLE;
        end
      end
      bft_pkg::S_FETCH: begin
        if (!pend_valid_q || emit_ok) begin
          state_d = bft_pkg::S_DEG;
        end
      end
      bft_pkg::S_DEG:   state_d = bft_pkg::S_SCAN;
      bft_pkg::S_SCAN:  state_d = (idx_q < deg_q) ? bft_pkg::S_CHECK : bft_pkg::S_POP;
      bft_pkg::S_CHECK: state_d = bft_pkg::S_SCAN;
      default:          state_d = bft_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    act_d        = act_q;
    vtx_d        = vtx_q;
    nbr_d        = nbr_q;
    head_d       = head_q;
    tail_d       = tail_q;
    visited_d    = visited_q;
    cur_d        = cur_q;
    deg_d        = deg_q;
    idx_d        = idx_q;
    pend_valid_d = pend_valid_q;
    pend_vtx_d   = pend_vtx_q;

    emit        = 1'b0;
    emit_status = bft_pkg::ST_VISIT;
    emit_vtx    = '0;
    emit_last   = 1'b0;

    deg_rd_en_o   = 1'b0;
    deg_rd_addr_o = req_i.vertex[VW-1:0];
    deg_wr_en_o   = 1'b0;
    deg_wr_addr_o = vtx_q[VW-1:0];
    deg_wr_data_o = deg_rd_data_i + DW'(1);
    deg_clear_o   = 1'b0;
    nbr_rd_en_o   = 1'b0;
    nbr_rd_addr_o = NAW'(cur_q) * MAXD_A + NAW'(idx_q);
    nbr_wr_en_o   = 1'b0;
    nbr_wr_addr_o = NAW'(vtx_q[VW-1:0]) * MAXD_A + NAW'(deg_rd_data_i);
    nbr_wr_data_o = nbr_q[VW-1:0];
    q_wr_en_o     = 1'b0;
    q_wr_addr_o   = tail_q[VW-1:0];
    q_wr_data_o   = nbr_rd_data_i;
    q_rd_en_o     = 1'b0;
    q_rd_addr_o   = head_q[VW-1:0];

    unique case (state_q)
      bft_pkg::S_IDLE: begin
        if (in_fire) begin
          act_d       = req_i.action;
          vtx_d       = req_i.vertex;
          nbr_d       = req_i.neighbor;
          deg_rd_en_o = 1'b1;
          if ((req_i.action == bft_pkg::ACT_TRAVERSE) && start_ok) begin
            visited_d                        = '0;
            visited_d[req_i.vertex[VW-1:0]]  = 1'b1;
            q_wr_en_o                        = 1'b1;
            q_wr_addr_o                      = '0;
            q_wr_data_o                      = req_i.vertex[VW-1:0];
            head_d                           = '0;
            tail_d                           = (VW+1)'(1);
            pend_valid_d                     = 1'b0;
          end
        end
      end
      bft_pkg::S_APPEND: begin
        if (emit_ok) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          if (append_ok) begin
            emit_status = bft_pkg::ST_APPEND_OK;
            nbr_wr_en_o = 1'b1;
            deg_wr_en_o = 1'b1;
          end else begin
            emit_status = bft_pkg::ST_APPEND_DROP;
          end
        end
      end
      bft_pkg::S_CLEAR: begin
        if (emit_ok) begin
          emit        = 1'b1;
          emit_last   = 1'b1;
          emit_status = bft_pkg::ST_CLEAR_DONE;
          deg_clear_o = 1'b1;
        end
      end
      bft_pkg::S_POP: begin
        if (head_q < tail_q) begin
          q_rd_en_o = 1'b1;
          head_d    = head_q + (VW+1)'(1);
        end else if (emit_ok) begin
          // queue drained: the held vertex is the final visit
          emit         = 1'b1;
          emit_vtx     = pend_vtx_q;
          emit_last    = 1'b1;
          pend_valid_d = 1'b0;
        end
      end
      bft_pkg::S_FETCH: begin
        if (!pend_valid_q || emit_ok) begin
          emit          = pend_valid_q;
          emit_vtx      = pend_vtx_q;
          pend_valid_d  = 1'b1;
          pend_vtx_d    = q_rd_data_i;
          cur_d         = q_rd_data_i;
          deg_rd_en_o   = 1'b1;
          deg_rd_addr_o = q_rd_data_i;
        end
      end
      bft_pkg::S_DEG: begin
        deg_d = deg_rd_data_i;
        idx_d = '0;
      end
      bft_pkg::S_SCAN: begin
        if (idx_q < deg_q) begin
          nbr_rd_en_o = 1'b1;
          idx_d       = idx_q + DW'(1);
        end
      end
      bft_pkg::S_CHECK: begin
        if (!visited_q[nbr_rd_data_i] && (tail_q < NV_PTR)) begin
          visited_d[nbr_rd_data_i] = 1'b1;
          q_wr_en_o                = 1'b1;
          tail_d                   = tail_q + (VW+1)'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= bft_pkg::S_IDLE;
      head_q       <= '0;
      tail_q       <= '0;
      visited_q    <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      visited_q    <= visited_d;
      pend_valid_q <= pend_valid_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    vtx_q      <= vtx_d;
    nbr_q      <= nbr_d;
    cur_q      <= cur_d;
    deg_q      <= deg_d;
    idx_q      <= idx_d;
    pend_vtx_q <= pend_vtx_d;
    if (emit) begin
      out_status_q <= emit_status;
      out_vtx_q    <= bft_pkg::VERTEX_W'(emit_vtx);
      out_last_q   <= emit_last;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_status_q;
  assign rsp_o.visited_vertex = out_vtx_q;
  assign rsp_o.last           = out_last_q;

  // every queued vertex is marked visited, and nothing else is
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(visited_q) == int'(tail_q))
    else $error("visited count differs from queue tail");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q <= tail_q) && (tail_q <= NV_PTR))
    else $error("queue pointers out of order");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bft_pkg::S_DEG || state_q == bft_pkg::S_SCAN || state_q == bft_pkg::S_CHECK)
    |-> pend_valid_q)
    else $error("edge scan without a held vertex");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bft_pkg::S_SCAN || state_q == bft_pkg::S_CHECK) |-> (idx_q <= deg_q))
    else $error("edge index ran past the degree");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !rsp_o.ready) |-> !emit)
    else $error("result register overwritten before transfer");

endmodule

/* rtl/core/breadth_first_traversal.sv */
// Breadth-first traversal over a directed adjacency list held in on-chip memory.
// Append and clear commands take a degree read, then the write and the result.
// A traverse command keeps the block busy until its last visited vertex is placed
// in the result register: after the command it takes, for each visited vertex, a
// queue read, queue data, degree data and scan end step, plus a neighbor read and a
// visited check per stored edge of that vertex, then a final empty-queue check; the
// neighbor memory has a single read port and registered reads. Backpressure on the
// result channel stalls the walk. Commands are taken while an earlier result still
// waits for its transfer. Vertices at or above NUM_VERTICES (or above 63) are
// rejected on append and yield no visits.
module breadth_first_traversal #(
  parameter int unsigned NUM_VERTICES = 64,
  parameter int unsigned MAX_DEGREE   = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bft_in_if.sink     req_i,
  bft_out_if.source  rsp_o
);

  localparam int unsigned FIELD_SPAN = 2 ** bft_pkg::VERTEX_W;
  localparam int unsigned NV  = (NUM_VERTICES < FIELD_SPAN) ? NUM_VERTICES : FIELD_SPAN;
  localparam int unsigned VW  = $clog2(NV);
  localparam int unsigned DW  = $clog2(MAX_DEGREE + 1);
  localparam int unsigned NAW = $clog2((2 ** VW) * MAX_DEGREE);

  logic            deg_rd_en;
  logic [VW-1:0]   deg_rd_addr;
  logic [DW-1:0]   deg_rd_data;
  logic            deg_wr_en;
  logic [VW-1:0]   deg_wr_addr;
  logic [DW-1:0]   deg_wr_data;
  logic            deg_clear;
  logic            nbr_rd_en;
  logic [NAW-1:0]  nbr_rd_addr;
  logic [VW-1:0]   nbr_rd_data;
  logic            nbr_wr_en;
  logic [NAW-1:0]  nbr_wr_addr;
  logic [VW-1:0]   nbr_wr_data;
  logic            q_wr_en;
  logic [VW-1:0]   q_wr_addr;
  logic [VW-1:0]   q_wr_data;
  logic            q_rd_en;
  logic [VW-1:0]   q_rd_addr;
  logic [VW-1:0]   q_rd_data;

  bft_adj_mem #(
    .VW         (VW),
    .MAX_DEGREE (MAX_DEGREE),
    .DW         (DW),
    .NAW        (NAW)
  ) u_adj_mem (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .deg_rd_en_i    (deg_rd_en),
    .deg_rd_addr_i  (deg_rd_addr),
    .deg_rd_data_o  (deg_rd_data),
    .deg_wr_en_i    (deg_wr_en),
    .deg_wr_addr_i  (deg_wr_addr),
    .deg_wr_data_i  (deg_wr_data),
    .deg_clear_i    (deg_clear),
    .nbr_rd_en_i    (nbr_rd_en),
    .nbr_rd_addr_i  (nbr_rd_addr),
    .nbr_rd_data_o  (nbr_rd_data),
    .nbr_wr_en_i    (nbr_wr_en),
    .nbr_wr_addr_i  (nbr_wr_addr),
    .nbr_wr_data_i  (nbr_wr_data)
  );

  bft_vfifo #(
    .VW (VW)
  ) u_vfifo (
    .clk_i     (clk_i),
    .wr_en_i   (q_wr_en),
    .wr_addr_i (q_wr_addr),
    .wr_data_i (q_wr_data),
    .rd_en_i   (q_rd_en),
    .rd_addr_i (q_rd_addr),
    .rd_data_o (q_rd_data)
  );

  bft_ctrl #(
    .NV         (NV),
    .VW         (VW),
    .MAX_DEGREE (MAX_DEGREE),
    .DW         (DW),
    .NAW        (NAW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req_i),
    .rsp_o          (rsp_o),
    .deg_rd_en_o    (deg_rd_en),
    .deg_rd_addr_o  (deg_rd_addr),
    .deg_rd_data_i  (deg_rd_data),
    .deg_wr_en_o    (deg_wr_en),
    .deg_wr_addr_o  (deg_wr_addr),
    .deg_wr_data_o  (deg_wr_data),
    .deg_clear_o    (deg_clear),
    .nbr_rd_en_o    (nbr_rd_en),
    .nbr_rd_addr_o  (nbr_rd_addr),
    .nbr_rd_data_i  (nbr_rd_data),
    .nbr_wr_en_o    (nbr_wr_en),
    .nbr_wr_addr_o  (nbr_wr_addr),
    .nbr_wr_data_o  (nbr_wr_data),
    .q_wr_en_o      (q_wr_en),
    .q_wr_addr_o    (q_wr_addr),
    .q_wr_data_o    (q_wr_data),
    .q_rd_en_o      (q_rd_en),
    .q_rd_addr_o    (q_rd_addr),
    .q_rd_data_i    (q_rd_data)
  );

endmodule

/* dv/tb_breadth_first_traversal.sv */
// testbench for the breadth-first traversal block: directed and random commands, scoreboard
`timescale 1ns / 1ps

module tb_breadth_first_traversal;

  localparam int NV   = 64;
  localparam int MAXD = 8;
  localparam logic [bft_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [bft_pkg::ACTION_W-1:0] action;
    logic [bft_pkg::VERTEX_W-1:0] vertex;
    logic [bft_pkg::VERTEX_W-1:0] neighbor;
  } cmd_t;

  typedef struct packed {
    bft_pkg::status_e             status;
    logic [bft_pkg::VERTEX_W-1:0] vis;
    logic                         last;
  } rsp_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  bft_in_if  req_if ();
  bft_out_if rsp_if ();

  // driven values live in initialised variables so the ports are known from time zero
  logic cmd_valid = 1'b0;
  cmd_t cmd_word  = '0;
  logic rsp_ready = 1'b0;

  assign req_if.valid    = cmd_valid;
  assign req_if.action   = cmd_word.action;
  assign req_if.vertex   = cmd_word.vertex;
  assign req_if.neighbor = cmd_word.neighbor;
  assign rsp_if.ready    = rsp_ready;

  breadth_first_traversal #(
    .NUM_VERTICES(NV),
    .MAX_DEGREE  (MAXD)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // adjacency lists as the block should hold them
  logic [bft_pkg::VERTEX_W-1:0] adj_mem [NV][MAXD];
  logic [3:0]                   deg_of  [NV] = '{default: '0};

  cmd_t cmd_backlog [$];
  rsp_t awaited     [$];
  rsp_t exp_rsp;

  int   n_queued    = 0;
  int   n_taken     = 0;
  int   fault_count = 0;
  int   send_gap    = 0;
  int   recv_gap    = 0;
  bit   calm_tx     = 1'b0;
  bit   calm_rx     = 1'b1;
  logic hold_rx     = 1'b0;

  function automatic int pick_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic void note_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("%s", msg);
  endfunction

  // works out every result that one accepted command should produce
  function automatic void compute_responses(input cmd_t c);
    rsp_t                         r;
    logic [bft_pkg::VERTEX_W-1:0] frontier [$];
    logic [bft_pkg::VERTEX_W-1:0] cur;
    logic [bft_pkg::VERTEX_W-1:0] nb;
    bit                           reached [NV];
    r.status = bft_pkg::ST_VISIT;
    r.vis    = '0;
    r.last   = 1'b1;
    case (c.action)
      bft_pkg::ACT_APPEND: begin
        if (deg_of[c.vertex] >= MAXD) begin
          r.status = bft_pkg::ST_APPEND_DROP;
        end else begin
          adj_mem[c.vertex][deg_of[c.vertex]] = c.neighbor;
          deg_of[c.vertex] = deg_of[c.vertex] + 1'b1;
          r.status = bft_pkg::ST_APPEND_OK;
        end
        awaited.push_back(r);
      end
      bft_pkg::ACT_CLEAR: begin
        foreach (deg_of[i]) deg_of[i] = '0;
        r.status = bft_pkg::ST_CLEAR_DONE;
        awaited.push_back(r);
      end
      bft_pkg::ACT_TRAVERSE: begin
        foreach (reached[i]) reached[i] = 1'b0;
        reached[c.vertex] = 1'b1;
        frontier.push_back(c.vertex);
        while (frontier.size() > 0) begin
          cur = frontier.pop_front();
          for (int i = 0; i < deg_of[cur]; i++) begin
            nb = adj_mem[cur][i];
            if (!reached[nb]) begin
              reached[nb] = 1'b1;
              frontier.push_back(nb);
            end
          end
          r.vis  = cur;
          r.last = (frontier.size() == 0);
          awaited.push_back(r);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void queue_cmd(input logic [bft_pkg::ACTION_W-1:0] a, input int v,
                                    input int nb);
    cmd_t c;
    c.action   = a;
    c.vertex   = v[bft_pkg::VERTEX_W-1:0];
    c.neighbor = nb[bft_pkg::VERTEX_W-1:0];
    cmd_backlog.push_back(c);
    if (a != ACT_UNUSED) n_queued++;
  endfunction

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // command driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && req_if.ready) begin
        compute_responses(cmd_word);
        n_taken  <= n_taken + 1;
        send_gap = pick_wait(calm_tx);
        if ($urandom_range(0, 19) == 0) calm_tx = !calm_tx;
      end
      if (cmd_valid && !req_if.ready) begin
        // hold the offered command until it transfers
      end else if (send_gap > 0) begin
        send_gap--;
        cmd_valid <= 1'b0;
      end else if (cmd_backlog.size() > 0) begin
        cmd_word  <= cmd_backlog.pop_front();
        cmd_valid <= 1'b1;
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // result monitor and scoreboard
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_ready) begin
        if (awaited.size() == 0) begin
          note_fault($sformatf("unexpected result: status %0d vertex %0d last %0d",
                               rsp_if.status, rsp_if.visited_vertex, rsp_if.last));
        end else begin
          exp_rsp = awaited.pop_front();
          if (rsp_if.status !== exp_rsp.status || rsp_if.visited_vertex !== exp_rsp.vis ||
              rsp_if.last !== exp_rsp.last)
            note_fault($sformatf(
              "mismatch: expected status %0d vertex %0d last %0d, got %0d %0d %0d",
              exp_rsp.status, exp_rsp.vis, exp_rsp.last,
              rsp_if.status, rsp_if.visited_vertex, rsp_if.last));
        end
        recv_gap = pick_wait(calm_rx);
        if ($urandom_range(0, 19) == 0) calm_rx = !calm_rx;
      end
      if (hold_rx) begin
        rsp_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // long receiver hold-off so the block backs up and stalls its input
  initial begin
    while (n_taken < 100) @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  initial begin
    #(20_000_000);
    $display("tb_breadth_first_traversal: FAIL");
    $finish;
  end

  initial begin
    int  base;
    int  span;
    int  k;
    int  j;
    int  tmp;
    int  perm [NV];
    bit  big_done;
    big_done = 1'b0;

    // directed: empty list, extremes, self loop, duplicate, full list, clear
    queue_cmd(bft_pkg::ACT_TRAVERSE, 5, 0);
    queue_cmd(bft_pkg::ACT_APPEND, 0, 63);
    queue_cmd(bft_pkg::ACT_APPEND, 0, 0);
    queue_cmd(bft_pkg::ACT_APPEND, 0, 63);
    queue_cmd(bft_pkg::ACT_APPEND, 63, 1);
    queue_cmd(bft_pkg::ACT_APPEND, 1, 0);
    queue_cmd(bft_pkg::ACT_TRAVERSE, 0, 63);
    repeat (9) queue_cmd(bft_pkg::ACT_APPEND, 7, $urandom_range(0, NV-1));
    queue_cmd(ACT_UNUSED, 63, 63);
    queue_cmd(bft_pkg::ACT_TRAVERSE, 63, 0);
    queue_cmd(bft_pkg::ACT_CLEAR, 63, 63);
    queue_cmd(bft_pkg::ACT_TRAVERSE, 0, 0);
    queue_cmd(bft_pkg::ACT_APPEND, 63, 0);
    queue_cmd(bft_pkg::ACT_TRAVERSE, 63, 63);

    while (n_queued < 330) begin
      if (!big_done && n_queued >= 150) begin
        // one ring through every vertex gives the longest walk
        queue_cmd(bft_pkg::ACT_CLEAR, $urandom, $urandom);
        for (j = 0; j < NV; j++) perm[j] = j;
        for (j = NV-1; j > 0; j--) begin
          k = $urandom_range(0, j);
          tmp = perm[j];
          perm[j] = perm[k];
          perm[k] = tmp;
        end
        for (j = 0; j < NV; j++) queue_cmd(bft_pkg::ACT_APPEND, perm[j], perm[(j+1) % NV]);
        queue_cmd(bft_pkg::ACT_TRAVERSE, perm[$urandom_range(0, NV-1)], $urandom);
        big_done = 1'b1;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            // dense graph over a small window of vertices, then walks inside it
            if ($urandom_range(0, 3) != 0) queue_cmd(bft_pkg::ACT_CLEAR, $urandom, $urandom);
            base = $urandom_range(0, NV-1);
            span = $urandom_range(2, 16);
            repeat ($urandom_range(span, 3*span))
              queue_cmd(bft_pkg::ACT_APPEND, (base + $urandom_range(0, span-1)) % NV,
                        ($urandom_range(0, 7) == 0) ? $urandom_range(0, NV-1)
                                                    : (base + $urandom_range(0, span-1)) % NV);
            repeat ($urandom_range(1, 3))
              queue_cmd(bft_pkg::ACT_TRAVERSE, (base + $urandom_range(0, span-1)) % NV,
                        $urandom);
          end
          6: begin
            repeat ($urandom_range(1, 6))
              queue_cmd(bft_pkg::ACTION_W'($urandom_range(0, 3)), $urandom_range(0, NV-1),
                        $urandom_range(0, NV-1));
          end
          7: begin
            k = $urandom_range(0, NV-1);
            repeat ($urandom_range(9, 11))
              queue_cmd(bft_pkg::ACT_APPEND, k, $urandom_range(0, NV-1));
            queue_cmd(bft_pkg::ACT_TRAVERSE, k, $urandom);
          end
          default: begin
            // build cut short by a clear
            k = $urandom_range(0, NV-1);
            repeat ($urandom_range(2, 5))
              queue_cmd(bft_pkg::ACT_APPEND, k, $urandom_range(0, NV-1));
            queue_cmd(bft_pkg::ACT_CLEAR, $urandom, $urandom);
            queue_cmd(bft_pkg::ACT_TRAVERSE, k, $urandom);
          end
        endcase
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_backlog.size() != 0 || cmd_valid) @(posedge clk_i);
    while (awaited.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (fault_count == 0)
      $display("tb_breadth_first_traversal: PASS");
    else
      $display("tb_breadth_first_traversal: FAIL");
    $finish;
  end

endmodule
